/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rio_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rio_pkg
// Types, address map and helpers of the RAM, I/O and interval timer block.
// ----------------------------------------------------------------------------
package rio_pkg;

    localparam int RAM_BYTES = 128;
    localparam int RAM_AW    = $clog2(RAM_BYTES);
    localparam int COUNT_W   = 19;

    typedef enum logic [2:0] {
        REQ_READ  = 3'd0,
        REQ_WRITE = 3'd1,
        REQ_TICK  = 3'd2,
        REQ_SET_A = 3'd3,
        REQ_SET_B = 3'd4
    } req_t;

    // Prescaler select, coded as the low two bits of the load address
    typedef enum logic [1:0] {
        SCALE_1    = 2'd0,
        SCALE_8    = 2'd1,
        SCALE_64   = 2'd2,
        SCALE_1024 = 2'd3
    } scale_t;

    localparam logic [15:0] ADDR_PORT_A  = 16'h0080;
    localparam logic [15:0] ADDR_DIR_A   = 16'h0081;
    localparam logic [15:0] ADDR_PORT_B  = 16'h0082;
    localparam logic [15:0] ADDR_DIR_B   = 16'h0083;
    localparam logic [15:0] ADDR_TIMER   = 16'h0084;
    localparam logic [15:0] ADDR_STATUS  = 16'h0085;
    localparam logic [15:0] ADDR_LOAD_1  = 16'h0094;
    localparam logic [15:0] ADDR_LOAD_8  = 16'h0095;
    localparam logic [15:0] ADDR_LOAD_64 = 16'h0096;
    localparam logic [15:0] ADDR_LOAD_1K = 16'h0097;

    localparam logic [7:0] STATUS_EXPIRED = 8'h80;
    localparam logic [7:0] TIMER_IDLE_VAL = 8'hFF;
    localparam logic [7:0] PORT_RESET_VAL = 8'hFF;

    typedef struct packed {
        logic accept;    // input transfer this cycle
        logic ram_done;  // registered RAM data is ready for the output
    } ctrl_cmd_t;

    typedef struct packed {
        logic ram_read;       // offered item is a RAM read
        logic out_blocked;    // output register full and not drained
        logic timer_running;  // count is nonzero
        logic expired;        // expired flag
    } dp_status_t;

    function automatic logic [3:0] scale_shift(input scale_t s);
        logic [3:0] sh;
        case (s)
            SCALE_1:    sh = 4'd0;
            SCALE_8:    sh = 4'd3;
            SCALE_64:   sh = 4'd6;
            SCALE_1024: sh = 4'd10;
            default:    sh = 4'd0;
        endcase
        return sh;
    endfunction

    // Mirror the 128-byte window onto the RAM; at most eight subtract steps
    function automatic logic [RAM_AW-1:0] ram_index(input logic [6:0] a);
        logic [7:0] r;
        r = {1'b0, a};
        for (int i = 0; i < 8; i++) begin
            if (r >= 8'(RAM_BYTES)) begin
                r = r - 8'(RAM_BYTES);
            end
        end
        return r[RAM_AW-1:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/ram_io_interval_timer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ram_io_interval_timer
// Scratch RAM, two I/O ports with direction registers and an interval timer,
// driven by a stream of bus reads, writes, ticks and pin updates.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload
//  --------+-----+-------------------------------------------------------------
//  s_      | in  | tuser: req_type; tdata: bus_address, write_data, elapsed_cycles
//  m_      | out | tdata: read_data, expired_flag
//
//  One result per transfer. RAM reads pass the registered RAM read port, then the
//  output register; the next item enters once the previous one is done.
//  A held result does not block the input while m_tready drains it that cycle.
//  Synchronous active-low reset; RAM entries read as zero until written
//  (per-entry valid flops), so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ram_io_interval_timer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_tuser,   // [2:0] req_type
    input  wire logic [39:0] s_tdata,   // [15:0] bus_address, [23:16] write_data,
                                        // [39:24] elapsed_cycles
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // [7:0] read_data, [8] expired_flag, [15:9] zero
);

    rio_pkg::ctrl_cmd_t  cmd;
    rio_pkg::dp_status_t status;

    rio_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rio_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

    `ASSERT_SAME(a_no_accept_when_blocked, m_tvalid && !m_tready, !s_tready,
                 "input taken while output blocked")
    `ASSERT_NEXT(a_plain_item_result, cmd.accept && !status.ram_read, m_tvalid,
                 "no result after item")
    `ASSERT_NEXT(a_ram_read_result, cmd.accept && status.ram_read,
                 !s_tready ##1 m_tvalid, "RAM read result missing")
    `ASSERT_SAME(a_running_not_expired, status.timer_running, !status.expired,
                 "expired with count left")

endmodule
`default_nettype wire

/* hdl/rio_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rio_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

/* hdl/rio_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rio_ctrl
// Sequencer: takes one item at a time, holds the input in ST_RAM_WAIT for RAM reads.
// ----------------------------------------------------------------------------
module rio_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire rio_pkg::dp_status_t status,
    output rio_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RAM_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        s_tready     = (state_reg == ST_IDLE) && !status.out_blocked;
        cmd.accept   = s_tvalid && s_tready;
        cmd.ram_done = (state_reg == ST_RAM_WAIT);
        case (state_reg)
            ST_IDLE:     state_next = (cmd.accept && status.ram_read) ? ST_RAM_WAIT : ST_IDLE;
            ST_RAM_WAIT: state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/rio_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rio_dp
// Datapath: scratch RAM, port and direction registers, interval timer and
// the output register.
// ----------------------------------------------------------------------------
module rio_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [2:0]         s_tuser,
    input  wire logic [39:0]        s_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [15:0]        m_tdata,
    input  wire rio_pkg::ctrl_cmd_t cmd,
    output rio_pkg::dp_status_t     status
);

    rio_pkg::req_t            req;
    logic [15:0]              addr;
    logic [7:0]               wdata;
    logic [15:0]              cycles;
    logic                     addr_is_ram;
    logic [rio_pkg::RAM_AW-1:0] ram_addr;
    logic                     ram_we;
    logic [7:0]               ram_rdata;

    logic [7:0]                    port_a_reg, port_a_next;
    logic [7:0]                    port_b_reg, port_b_next;
    logic [7:0]                    dir_a_reg, dir_a_next;
    logic [7:0]                    dir_b_reg, dir_b_next;
    logic [rio_pkg::COUNT_W-1:0]   count_reg, count_next;
    rio_pkg::scale_t               scale_reg, scale_next;
    logic                          expired_reg, expired_next;
    logic [rio_pkg::RAM_BYTES-1:0] ram_valid_reg;
    logic                          hit_valid_reg;
    logic [7:0]                    out_data_reg, out_data_next;
    logic                          out_flag_reg, out_flag_next;
    logic                          out_valid_reg, out_valid_next;

    logic [7:0]                    rd;
    logic [rio_pkg::COUNT_W-1:0]   count_m1;
    logic [rio_pkg::COUNT_W-1:0]   count_shifted;
    logic [rio_pkg::COUNT_W-1:0]   cycles_ext;
    logic [8:0]                    load_base;

    assign req         = rio_pkg::req_t'(s_tuser);
    assign addr        = s_tdata[15:0];
    assign wdata       = s_tdata[23:16];
    assign cycles      = s_tdata[39:24];
    assign addr_is_ram = (addr[15:7] == 9'd0);
    assign ram_addr    = rio_pkg::ram_index(addr[6:0]);
    assign ram_we      = cmd.accept && (req == rio_pkg::REQ_WRITE) && addr_is_ram;

    assign count_m1      = count_reg - rio_pkg::COUNT_W'(1);
    assign count_shifted = count_m1 >> rio_pkg::scale_shift(scale_reg);
    assign cycles_ext    = rio_pkg::COUNT_W'(cycles);
    assign load_base     = {1'b0, wdata} + 9'd1;

    rio_ram #(
        .WIDTH (8),
        .DEPTH (rio_pkg::RAM_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        port_a_next    = port_a_reg;
        port_b_next    = port_b_reg;
        dir_a_next     = dir_a_reg;
        dir_b_next     = dir_b_reg;
        count_next     = count_reg;
        scale_next     = scale_reg;
        expired_next   = expired_reg;
        rd             = 8'd0;
        out_data_next  = out_data_reg;
        out_flag_next  = out_flag_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cmd.accept) begin
            case (req)
                rio_pkg::REQ_READ: begin
                    if (!addr_is_ram) begin
                        case (addr)
                            rio_pkg::ADDR_PORT_A: rd = port_a_reg;
                            rio_pkg::ADDR_PORT_B: rd = port_b_reg;
                            rio_pkg::ADDR_DIR_B:  rd = dir_b_reg;
                            rio_pkg::ADDR_TIMER: begin
                                rd = (count_reg != '0) ? count_shifted[7:0]
                                                       : rio_pkg::TIMER_IDLE_VAL;
                            end
                            rio_pkg::ADDR_STATUS: begin
                                rd           = expired_reg ? rio_pkg::STATUS_EXPIRED : 8'd0;
                                expired_next = 1'b0;
                            end
                            default: rd = 8'd0;
                        endcase
                    end
                end
                rio_pkg::REQ_WRITE: begin
                    case (addr)
                        rio_pkg::ADDR_PORT_A: begin
                            port_a_next = (wdata & dir_a_reg) | (port_a_reg & ~dir_a_reg);
                        end
                        rio_pkg::ADDR_DIR_A: dir_a_next = wdata;
                        rio_pkg::ADDR_DIR_B: dir_b_next = wdata;
                        rio_pkg::ADDR_LOAD_1, rio_pkg::ADDR_LOAD_8,
                        rio_pkg::ADDR_LOAD_64, rio_pkg::ADDR_LOAD_1K: begin
                            scale_next   = rio_pkg::scale_t'(addr[1:0]);
                            count_next   = rio_pkg::COUNT_W'(load_base)
                                           << rio_pkg::scale_shift(rio_pkg::scale_t'(addr[1:0]));
                            expired_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
                rio_pkg::REQ_TICK: begin
                    if (count_reg != '0) begin
                        if (cycles_ext >= count_reg) begin
                            expired_next = 1'b1;
                            scale_next   = rio_pkg::SCALE_1;
                            count_next   = '0;
                        end else begin
                            count_next = count_reg - cycles_ext;
                        end
                    end
                end
                rio_pkg::REQ_SET_A: port_a_next = wdata;
                rio_pkg::REQ_SET_B: port_b_next = wdata;
                default: ;
            endcase

            // RAM reads finish in ST_RAM_WAIT from the registered RAM data
            if (!((req == rio_pkg::REQ_READ) && addr_is_ram)) begin
                out_data_next  = rd;
                out_flag_next  = expired_next;
                out_valid_next = 1'b1;
            end
        end

        if (cmd.ram_done) begin
            out_data_next  = hit_valid_reg ? ram_rdata : 8'd0;
            out_flag_next  = expired_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_a_reg    <= rio_pkg::PORT_RESET_VAL;
            port_b_reg    <= rio_pkg::PORT_RESET_VAL;
            dir_a_reg     <= 8'd0;
            dir_b_reg     <= 8'd0;
            count_reg     <= '0;
            scale_reg     <= rio_pkg::SCALE_1;
            expired_reg   <= 1'b0;
            ram_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            port_a_reg    <= port_a_next;
            port_b_reg    <= port_b_next;
            dir_a_reg     <= dir_a_next;
            dir_b_reg     <= dir_b_next;
            count_reg     <= count_next;
            scale_reg     <= scale_next;
            expired_reg   <= expired_next;
            out_valid_reg <= out_valid_next;
            if (ram_we) begin
                ram_valid_reg[ram_addr] <= 1'b1;
            end
        end
    end

    // Entries never written read as zero
    always_ff @(posedge aclk) begin
        hit_valid_reg <= ram_valid_reg[ram_addr];
        out_data_reg  <= out_data_next;
        out_flag_reg  <= out_flag_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_flag_reg, out_data_reg};

    assign status.ram_read      = (req == rio_pkg::REQ_READ) && addr_is_ram;
    assign status.out_blocked   = out_valid_reg && !m_tready;
    assign status.timer_running = (count_reg != '0);
    assign status.expired       = expired_reg;

endmodule
`default_nettype wire

/* bench/ram_io_interval_timer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ram_io_interval_timer_test
// Self-checking bench for the RAM, I/O and interval timer block. A directed
// sequence covers the address map, the direction masks and timer expiry. A
// random mix of bus reads, writes, ticks and pin updates follows. Both stream
// sides idle at random. A local model of the block predicts every result.
// ----------------------------------------------------------------------------
module ram_io_interval_timer_test;
    import rio_pkg::*;

    localparam logic [2:0] REQ_RSVD_LO = 3'd5;
    localparam logic [2:0] REQ_RSVD_HI = 3'd7;
    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [15:0] cycles;
    } bus_item_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       flag;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser = '0;   // [2:0] req_type
    logic [39:0] s_tdata = '0;   // [15:0] bus_address, [23:16] write_data,
                                 // [39:24] elapsed_cycles
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;       // [7:0] read_data, [8] expired_flag

    ram_io_interval_timer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the block state
    logic [7:0] ram_image [RAM_BYTES];
    logic [7:0] pins_a = PORT_RESET_VAL;
    logic [7:0] pins_b = PORT_RESET_VAL;
    logic [7:0] mask_a = '0;
    logic [7:0] mask_b = '0;
    int         count_rem = 0;
    int         tick_div = 1;
    logic       timer_fired = 1'b0;

    bus_item_t  bus_items [$];
    outcome_t   pending_results [$];
    bus_item_t  cur_item;
    outcome_t   want;
    int         hold_left = 0;
    int         stall_left = 0;
    logic       calm_src = 1'b0;
    logic       calm_snk = 1'b0;
    int         errors = 0;

    function automatic void arm_timer(input logic [7:0] v, input int div);
        count_rem   = (int'(v) + 1) * div;
        tick_div    = div;
        timer_fired = 1'b0;
    endfunction

    function automatic logic [7:0] timer_reading();
        if (count_rem == 0) begin
            return TIMER_IDLE_VAL;
        end
        return 8'((count_rem - 1) / tick_div);
    endfunction

    function automatic outcome_t apply_bus_item(input bus_item_t it);
        outcome_t o;
        o.rd = 8'h00;
        case (it.kind)
            REQ_READ: begin
                if (it.addr < ADDR_PORT_A) begin
                    o.rd = ram_image[it.addr % RAM_BYTES];
                end else begin
                    case (it.addr)
                        ADDR_PORT_A: o.rd = pins_a;
                        ADDR_PORT_B: o.rd = pins_b;
                        ADDR_DIR_B:  o.rd = mask_b;
                        ADDR_TIMER:  o.rd = timer_reading();
                        ADDR_STATUS: begin
                            o.rd = timer_fired ? STATUS_EXPIRED : 8'h00;
                            timer_fired = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            REQ_WRITE: begin
                if (it.addr < ADDR_PORT_A) begin
                    ram_image[it.addr % RAM_BYTES] = it.data;
                end else begin
                    case (it.addr)
                        ADDR_PORT_A:  pins_a = (it.data & mask_a) | (pins_a & ~mask_a);
                        ADDR_DIR_A:   mask_a = it.data;
                        ADDR_DIR_B:   mask_b = it.data;
                        ADDR_LOAD_1:  arm_timer(it.data, 1);
                        ADDR_LOAD_8:  arm_timer(it.data, 8);
                        ADDR_LOAD_64: arm_timer(it.data, 64);
                        ADDR_LOAD_1K: arm_timer(it.data, 1024);
                        default: ;
                    endcase
                end
            end
            REQ_TICK: begin
                if (count_rem > 0) begin
                    if (int'(it.cycles) >= count_rem) begin
                        timer_fired = 1'b1;
                        tick_div    = 1;
                        count_rem   = 0;
                    end else begin
                        count_rem = count_rem - int'(it.cycles);
                    end
                end
            end
            REQ_SET_A: pins_a = it.data;
            REQ_SET_B: pins_b = it.data;
            default: ;
        endcase
        o.flag = timer_fired;
        return o;
    endfunction

    task automatic add_item(input logic [2:0] kind, input logic [15:0] addr,
                            input logic [7:0] data, input logic [15:0] cycles);
        bus_item_t it;
        it.kind   = kind;
        it.addr   = addr;
        it.data   = data;
        it.cycles = cycles;
        bus_items.push_back(it);
    endtask

    task automatic add_random_item();
        bus_item_t it;
        int k;
        int c;
        it.kind   = REQ_READ;
        it.addr   = 16'($urandom_range(0, 65535));
        it.data   = 8'($urandom_range(0, 255));
        it.cycles = 16'($urandom_range(0, 65535));
        k = $urandom_range(0, 99);
        if (k < 30 || k >= 97) begin
            c = $urandom_range(0, 11);
            case (c)
                0, 1, 2, 3: it.addr = 16'($urandom_range(0, 127));
                4:          it.addr = ADDR_PORT_A;
                5:          it.addr = ADDR_PORT_B;
                6:          it.addr = ADDR_DIR_B;
                7, 8:       it.addr = ADDR_TIMER;
                9, 10:      it.addr = ADDR_STATUS;
                default: begin
                    if ($urandom_range(0, 1) == 0) begin
                        it.addr = ADDR_DIR_A + 16'($urandom_range(0, 31));
                    end
                end
            endcase
        end else if (k < 55) begin
            it.kind = REQ_WRITE;
            c = $urandom_range(0, 11);
            case (c)
                0, 1, 2: it.addr = 16'($urandom_range(0, 127));
                3:       it.addr = ADDR_PORT_A;
                4:       it.addr = ADDR_DIR_A;
                5:       it.addr = ADDR_DIR_B;
                6, 7, 8: begin
                    it.addr = ADDR_LOAD_1 + 16'($urandom_range(0, 3));
                    if ($urandom_range(0, 1) == 0) begin
                        it.data = 8'($urandom_range(0, 15));
                    end
                end
                9:       it.addr = ADDR_PORT_B;
                10:      ;
                default: it.addr = ($urandom_range(0, 1) == 0) ? ADDR_TIMER : ADDR_STATUS;
            endcase
        end else if (k < 82) begin
            it.kind = REQ_TICK;
            c = $urandom_range(0, 9);
            if (c < 7) begin
                it.cycles = 16'($urandom_range(0, 64));
            end else if (c < 9) begin
                it.cycles = 16'($urandom_range(0, 2048));
            end
        end else if (k < 88) begin
            it.kind = REQ_SET_A;
        end else if (k < 94) begin
            it.kind = REQ_SET_B;
        end else begin
            it.kind = 3'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
        end
        bus_items.push_back(it);
    endtask

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Source side: hold the item until taken, then idle for a drawn gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(apply_bus_item(cur_item));
                hold_left = calm_src ? 0 : $urandom_range(0, 13);
                if ($urandom_range(0, 39) == 0) begin
                    calm_src = ~calm_src;
                end
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transfer
            end else if (hold_left > 0) begin
                hold_left = hold_left - 1;
                s_tvalid <= 1'b0;
            end else if (bus_items.size() > 0) begin
                cur_item = bus_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur_item.kind;
                s_tdata  <= {cur_item.cycles, cur_item.data, cur_item.addr};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: check each result transfer, then stall for a drawn time
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, got read_data %02h expired %0b",
                             $time, m_tdata[7:0], m_tdata[8]);
                    errors = errors + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[7:0] !== want.rd) begin
                        $display("%0t: read_data expected %02h, got %02h",
                                 $time, want.rd, m_tdata[7:0]);
                        errors = errors + 1;
                    end
                    if (m_tdata[8] !== want.flag) begin
                        $display("%0t: expired_flag expected %0b, got %0b",
                                 $time, want.flag, m_tdata[8]);
                        errors = errors + 1;
                    end
                end
                stall_left = calm_snk ? 0 : $urandom_range(0, 13);
                if ($urandom_range(0, 39) == 0) begin
                    calm_snk = ~calm_snk;
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("[ram_io_interval_timer] ERROR");
        $finish;
    end

    initial begin
        for (int i = 0; i < RAM_BYTES; i++) begin
            ram_image[i] = 8'h00;
        end

        // Reset values and unmapped reads
        add_item(REQ_READ, ADDR_PORT_A, 8'h00, 16'h0000);
        add_item(REQ_READ, ADDR_TIMER, 8'h00, 16'h0000);
        add_item(REQ_READ, ADDR_DIR_A, 8'hFF, 16'hFFFF);
        add_item(REQ_READ, 16'hFFFF, 8'h00, 16'h0000);
        // RAM boundary addresses and an out-of-window write
        add_item(REQ_WRITE, 16'h0000, 8'hA5, 16'h0000);
        add_item(REQ_WRITE, 16'h007F, 8'h5A, 16'h0000);
        add_item(REQ_WRITE, 16'h0100, 8'hEE, 16'h0000);
        add_item(REQ_READ, 16'h0000, 8'h00, 16'h0000);
        add_item(REQ_READ, 16'h007F, 8'h00, 16'h0000);
        // Direction masks and pin updates
        add_item(REQ_WRITE, ADDR_DIR_A, 8'h0F, 16'h0000);
        add_item(REQ_WRITE, ADDR_PORT_A, 8'h30, 16'h0000);
        add_item(REQ_READ, ADDR_PORT_A, 8'h00, 16'h0000);
        add_item(REQ_SET_A, 16'h0000, 8'h3C, 16'h0000);
        add_item(REQ_SET_B, 16'h0000, 8'h00, 16'h0000);
        add_item(REQ_WRITE, ADDR_PORT_B, 8'hFF, 16'h0000);
        add_item(REQ_WRITE, ADDR_DIR_B, 8'hFF, 16'h0000);
        add_item(REQ_READ, ADDR_DIR_B, 8'h00, 16'h0000);
        // Idle tick, load, expiry and status clear
        add_item(REQ_TICK, 16'h0000, 8'h00, 16'h0005);
        add_item(REQ_WRITE, ADDR_LOAD_1, 8'hFF, 16'h0000);
        add_item(REQ_READ, ADDR_TIMER, 8'h00, 16'h0000);
        add_item(REQ_TICK, 16'h0000, 8'h00, 16'hFFFF);
        add_item(REQ_READ, ADDR_STATUS, 8'h00, 16'h0000);
        add_item(REQ_READ, ADDR_STATUS, 8'h00, 16'h0000);
        add_item(REQ_WRITE, ADDR_LOAD_1K, 8'hFF, 16'h0000);
        add_item(REQ_TICK, 16'h0000, 8'h00, 16'd100);
        add_item(REQ_READ, ADDR_TIMER, 8'h00, 16'h0000);
        add_item(REQ_RSVD_HI, ADDR_STATUS, 8'hFF, 16'hFFFF);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            add_random_item();
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (bus_items.size() != 0 || s_tvalid || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("[ram_io_interval_timer] OK");
        end else begin
            $display("[ram_io_interval_timer] ERROR");
        end
        $finish;
    end

endmodule
